// ===== rtl/mpfc_pkg.sv =====
`default_nettype none
package mpfc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NUM_CH  = 4;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned BPP_W   = 6;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_RED_MASK   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_GREEN_MASK = 3'd1;
    localparam logic [CIDX_W-1:0] REG_BLUE_MASK  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_ALPHA_MASK = 3'd3;
    localparam logic [CIDX_W-1:0] REG_BPP        = 3'd4;
    localparam logic [CIDX_W-1:0] REG_DIRECTION  = 3'd5;

    // Channel slots, numbered by their byte lane in ARGB8888.
    localparam int unsigned CH_BLUE  = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_RED   = 2;
    localparam int unsigned CH_ALPHA = 3;

    localparam logic [WORD_W-1:0] RST_RED_MASK   = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] RST_GREEN_MASK = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [WORD_W-1:0] RST_ALPHA_MASK = 32'hFF00_0000;
    localparam logic [BPP_W-1:0]  RST_BPP        = 6'd32;
    localparam logic              DIR_PACK       = 1'b1;
    localparam logic              DIR_UNPACK     = 1'b0;

    localparam logic [BPP_W-1:0]  BPP_8  = 6'd8;
    localparam logic [BPP_W-1:0]  BPP_16 = 6'd16;
    localparam logic [BPP_W-1:0]  BPP_24 = 6'd24;
    localparam logic [BPP_W-1:0]  BPP_32 = 6'd32;

    typedef struct packed {
        logic [4:0] rshift;   // trailing zeros of the mask
        logic [3:0] lshift;   // 8 minus the mask span, clamped at 0
    } t_lane_shift;

    // Shift amounts of one channel mask. A zero mask gives a right shift of 0
    // and a left shift of 8, which removes the channel in both directions.
    function automatic t_lane_shift derive_shift(input logic [WORD_W-1:0] mask);
        t_lane_shift res;
        logic [4:0]  lo;
        logic [4:0]  hi;
        logic [5:0]  span;
        lo = '0;
        hi = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                lo = 5'(i);
            end
        end
        for (int i = 0; i < WORD_W; i++) begin
            if (mask[i]) begin
                hi = 5'(i);
            end
        end
        span = 6'({1'b0, hi} - {1'b0, lo}) + 6'd1;
        if (mask == '0) begin
            res.rshift = '0;
            res.lshift = 4'd8;
        end else begin
            res.rshift = lo;
            res.lshift = (span >= 6'd8) ? 4'd0 : 4'(6'd8 - span);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mpfc_in_if.sv =====
`default_nettype none
interface mpfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/mpfc_out_if.sv =====
`default_nettype none
interface mpfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] converted_word;

    modport source (output valid, output converted_word, input ready);
    modport sink   (input valid, input converted_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/masked_pixel_format_converter.sv =====
`default_nettype none
// Converts one pixel per item between ARGB8888 and a surface format given by
// four channel masks, a pixel size and a direction. The block takes one item
// every clock cycle while the output is not stalled. A result is presented from
// the result register: the item lands in the input register at the accepting
// edge and its result in the result register once the output is free. Both
// registers hold their item under output backpressure. The per-channel shift
// amounts are registered from the mask registers, so an item accepted in the
// cycle after a configuration write already sees the new format.
module masked_pixel_format_converter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mpfc_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  wire logic [mpfc_pkg::WORD_W-1:0]       i_cfg_data,
    mpfc_in_if.sink                                i_in,
    mpfc_out_if.source                             o_out
);

    logic [mpfc_pkg::WORD_W-1:0] r_mask [mpfc_pkg::NUM_CH];
    logic [mpfc_pkg::BPP_W-1:0]  r_bpp;
    logic                        r_dir;
    mpfc_pkg::t_lane_shift       r_shift [mpfc_pkg::NUM_CH];

    logic                        r_in_valid;
    logic [mpfc_pkg::WORD_W-1:0] r_in_word;
    logic                        r_out_valid;
    logic [mpfc_pkg::WORD_W-1:0] r_out_word;
    logic [mpfc_pkg::WORD_W-1:0] n_out_word;

    logic out_free;
    logic in_take;

    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[mpfc_pkg::CH_RED]   <= mpfc_pkg::RST_RED_MASK;
            r_mask[mpfc_pkg::CH_GREEN] <= mpfc_pkg::RST_GREEN_MASK;
            r_mask[mpfc_pkg::CH_BLUE]  <= mpfc_pkg::RST_BLUE_MASK;
            r_mask[mpfc_pkg::CH_ALPHA] <= mpfc_pkg::RST_ALPHA_MASK;
            r_bpp <= mpfc_pkg::RST_BPP;
            r_dir <= mpfc_pkg::DIR_PACK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mpfc_pkg::REG_RED_MASK:   r_mask[mpfc_pkg::CH_RED]   <= i_cfg_data;
                mpfc_pkg::REG_GREEN_MASK: r_mask[mpfc_pkg::CH_GREEN] <= i_cfg_data;
                mpfc_pkg::REG_BLUE_MASK:  r_mask[mpfc_pkg::CH_BLUE]  <= i_cfg_data;
                mpfc_pkg::REG_ALPHA_MASK: r_mask[mpfc_pkg::CH_ALPHA] <= i_cfg_data;
                mpfc_pkg::REG_BPP:        r_bpp <= i_cfg_data[mpfc_pkg::BPP_W-1:0];
                mpfc_pkg::REG_DIRECTION:  r_dir <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Shift amounts are registered from the mask registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift[mpfc_pkg::CH_RED]   <= mpfc_pkg::derive_shift(mpfc_pkg::RST_RED_MASK);
            r_shift[mpfc_pkg::CH_GREEN] <= mpfc_pkg::derive_shift(mpfc_pkg::RST_GREEN_MASK);
            r_shift[mpfc_pkg::CH_BLUE]  <= mpfc_pkg::derive_shift(mpfc_pkg::RST_BLUE_MASK);
            r_shift[mpfc_pkg::CH_ALPHA] <= mpfc_pkg::derive_shift(mpfc_pkg::RST_ALPHA_MASK);
        end else begin
            for (int c = 0; c < mpfc_pkg::NUM_CH; c++) begin
                r_shift[c] <= mpfc_pkg::derive_shift(r_mask[c]);
            end
        end
    end

    always_comb begin
        logic [mpfc_pkg::WORD_W-1:0] keep;
        logic [mpfc_pkg::WORD_W-1:0] pix;
        logic [mpfc_pkg::WORD_W-1:0] v;
        logic [mpfc_pkg::WORD_W-1:0] acc;
        logic [mpfc_pkg::CHAN_W-1:0] chan;
        keep = '0;
        pix = '0;
        v = '0;
        chan = '0;
        acc = '0;
        if (r_dir == mpfc_pkg::DIR_PACK) begin
            for (int c = 0; c < mpfc_pkg::NUM_CH; c++) begin
                chan = r_in_word[c*mpfc_pkg::CHAN_W +: mpfc_pkg::CHAN_W];
                v = mpfc_pkg::WORD_W'(chan >> r_shift[c].lshift);
                v = (v << r_shift[c].rshift) & r_mask[c];
                acc = acc | v;
            end
            if (r_bpp != mpfc_pkg::BPP_32) begin
                acc = {16'h0000, acc[15:0]};
            end
        end else begin
            keep = '0;
            if (r_bpp >= mpfc_pkg::BPP_8)  keep[7:0]   = 8'hFF;
            if (r_bpp >= mpfc_pkg::BPP_16) keep[15:8]  = 8'hFF;
            if (r_bpp >= mpfc_pkg::BPP_24) keep[23:16] = 8'hFF;
            if (r_bpp >= mpfc_pkg::BPP_32) keep[31:24] = 8'hFF;
            pix = r_in_word & keep;
            for (int c = 0; c < mpfc_pkg::NUM_CH; c++) begin
                v = (pix & r_mask[c]) >> r_shift[c].rshift;
                v = v << r_shift[c].lshift;
                // A wide mask may spill past its own byte lane; bits beyond 31 drop.
                acc = acc | (v << (c * mpfc_pkg::CHAN_W));
            end
        end
        n_out_word = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in.pixel_word;
        end
        if (out_free && r_in_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.converted_word = r_out_word;

endmodule
`default_nettype wire
